FILE: rtl/mrc_pkg.sv
// Shared types and constants of the mixed-radix index converter.
// No dependencies; used by every module of the block.
`default_nettype none

package mrc_pkg;

	// Fixed field and register widths
	localparam int FIELD_DIMS = 4;
	localparam int EXT_W      = 13;
	localparam int CNT_W      = 3;
	localparam int REG_W      = 32;
	localparam int ADDR_W     = 5;
	localparam int IDX_W      = 3;

	// Quotient bits worked out in one divider stage
	localparam int STEP_BITS = 4;

	// Defaults of the top-level parameters
	localparam int DEF_MAX_DIMS   = 4;
	localparam int DEF_COORD_BITS = 12;
	localparam int DEF_INDEX_BITS = 32;

	// Register indexes (byte address / 4)
	localparam logic [IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [IDX_W-1:0] REG_EXTENT_0  = 3'd1;
	localparam logic [IDX_W-1:0] REG_EXTENT_1  = 3'd2;
	localparam logic [IDX_W-1:0] REG_EXTENT_2  = 3'd3;
	localparam logic [IDX_W-1:0] REG_EXTENT_3  = 3'd4;

	// Reset values
	localparam logic [CNT_W-1:0] RST_DIM_COUNT = 3'd2;
	localparam logic [EXT_W-1:0] RST_EXTENT_0  = 13'd4096;
	localparam logic [EXT_W-1:0] RST_EXTENT_1  = 13'd4096;
	localparam logic [EXT_W-1:0] RST_EXTENT_2  = 13'd1;
	localparam logic [EXT_W-1:0] RST_EXTENT_3  = 13'd1;

	// Configuration as seen by the datapath: saturated count, extents with zero read as one
	typedef struct packed {
		logic [CNT_W-1:0]                  dims;
		logic [FIELD_DIMS-1:0][EXT_W-1:0]  ext;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/mrc_regs.sv
// APB register file of the converter: dimension count and four extents.
// Depends on mrc_pkg.
`default_nettype none

module mrc_regs #(
	parameter int MAX_DIMS = mrc_pkg::DEF_MAX_DIMS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mrc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mrc_pkg::REG_W-1:0]    pwdata,
	output logic      [mrc_pkg::REG_W-1:0]    prdata,
	output logic                              pready,
	output mrc_pkg::cfg_t                     cfg
);

	localparam int CAP = (MAX_DIMS < mrc_pkg::FIELD_DIMS) ? MAX_DIMS : mrc_pkg::FIELD_DIMS;

	logic [mrc_pkg::CNT_W-1:0]                          dim_count_q;
	logic [mrc_pkg::FIELD_DIMS-1:0][mrc_pkg::EXT_W-1:0] ext_q;
	logic [mrc_pkg::IDX_W-1:0]                          reg_idx;
	logic                                               wr_en;

	assign reg_idx = paddr[mrc_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= mrc_pkg::RST_DIM_COUNT;
			ext_q[0]    <= mrc_pkg::RST_EXTENT_0;
			ext_q[1]    <= mrc_pkg::RST_EXTENT_1;
			ext_q[2]    <= mrc_pkg::RST_EXTENT_2;
			ext_q[3]    <= mrc_pkg::RST_EXTENT_3;
		end else if (wr_en) begin
			case (reg_idx)
				mrc_pkg::REG_DIM_COUNT: dim_count_q <= pwdata[mrc_pkg::CNT_W-1:0];
				mrc_pkg::REG_EXTENT_0:  ext_q[0] <= pwdata[mrc_pkg::EXT_W-1:0];
				mrc_pkg::REG_EXTENT_1:  ext_q[1] <= pwdata[mrc_pkg::EXT_W-1:0];
				mrc_pkg::REG_EXTENT_2:  ext_q[2] <= pwdata[mrc_pkg::EXT_W-1:0];
				mrc_pkg::REG_EXTENT_3:  ext_q[3] <= pwdata[mrc_pkg::EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			mrc_pkg::REG_DIM_COUNT: prdata[mrc_pkg::CNT_W-1:0] = dim_count_q;
			mrc_pkg::REG_EXTENT_0:  prdata[mrc_pkg::EXT_W-1:0] = ext_q[0];
			mrc_pkg::REG_EXTENT_1:  prdata[mrc_pkg::EXT_W-1:0] = ext_q[1];
			mrc_pkg::REG_EXTENT_2:  prdata[mrc_pkg::EXT_W-1:0] = ext_q[2];
			mrc_pkg::REG_EXTENT_3:  prdata[mrc_pkg::EXT_W-1:0] = ext_q[3];
			default: prdata = '0;
		endcase
	end

	// Datapath view: count saturated, zero extent acts as one
	always_comb begin
		cfg.dims = (dim_count_q > mrc_pkg::CNT_W'(CAP)) ? mrc_pkg::CNT_W'(CAP) : dim_count_q;
		for (int d = 0; d < mrc_pkg::FIELD_DIMS; d++) begin
			cfg.ext[d] = (ext_q[d] == '0) ? mrc_pkg::EXT_W'(1) : ext_q[d];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mrc_stage.sv
// One pipeline stage: STEP_BITS steps of the restoring divide for dimension DIM,
// plus the pack multiply-accumulate on the first stage of each dimension. Depends on mrc_pkg.
`default_nettype none

module mrc_stage #(
	parameter int INDEX_BITS = mrc_pkg::DEF_INDEX_BITS,
	parameter int COORD_BITS = mrc_pkg::DEF_COORD_BITS,
	parameter int NUM_W      = mrc_pkg::DEF_INDEX_BITS,
	parameter int DIV_STAGES = 8,
	parameter int DIM        = 0,
	parameter int SUB        = 0
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire mrc_pkg::cfg_t                                 cfg,
	input  wire logic                                          in_valid,
	input  wire logic                                          in_kind,
	input  wire logic [NUM_W-1:0]                              in_num,
	input  wire logic [mrc_pkg::EXT_W-1:0]                     in_rem,
	input  wire logic [INDEX_BITS-1:0]                         in_acc,
	input  wire logic [INDEX_BITS-1:0]                         in_mult,
	input  wire logic [mrc_pkg::FIELD_DIMS-1:0][COORD_BITS-1:0] in_coord,
	output logic                                               out_valid,
	output logic                                               out_kind,
	output logic      [NUM_W-1:0]                              out_num,
	output logic      [mrc_pkg::EXT_W-1:0]                     out_rem,
	output logic      [INDEX_BITS-1:0]                         out_acc,
	output logic      [INDEX_BITS-1:0]                         out_mult,
	output logic      [mrc_pkg::FIELD_DIMS-1:0][COORD_BITS-1:0] out_coord
);

	logic                                               valid_s1;
	logic                                               kind_s1;
	logic [NUM_W-1:0]                                   num_s1;
	logic [mrc_pkg::EXT_W-1:0]                          rem_s1;
	logic [INDEX_BITS-1:0]                              acc_s1;
	logic [INDEX_BITS-1:0]                              mult_s1;
	logic [mrc_pkg::FIELD_DIMS-1:0][COORD_BITS-1:0]     coord_s1;

	logic                                               active;
	logic [mrc_pkg::EXT_W-1:0]                          ext;
	logic [NUM_W-1:0]                                   num_n;
	logic [mrc_pkg::EXT_W-1:0]                          rem_n;
	logic [mrc_pkg::EXT_W:0]                            trial;
	logic [INDEX_BITS-1:0]                              acc_n;
	logic [INDEX_BITS-1:0]                              mult_n;
	logic [mrc_pkg::FIELD_DIMS-1:0][COORD_BITS-1:0]     coord_n;

	assign active = mrc_pkg::CNT_W'(DIM) < cfg.dims;
	assign ext    = cfg.ext[DIM];

	// Divide steps; a new remainder starts at the first stage of each dimension
	always_comb begin
		num_n = in_num;
		rem_n = (SUB == 0) ? '0 : in_rem;
		trial = '0;
		if (active) begin
			for (int j = 0; j < mrc_pkg::STEP_BITS; j++) begin
				trial = {rem_n, num_n[NUM_W-1]};
				if (trial >= {1'b0, ext}) begin
					trial = trial - {1'b0, ext};
					num_n = {num_n[NUM_W-2:0], 1'b1};
				end else begin
					num_n = {num_n[NUM_W-2:0], 1'b0};
				end
				rem_n = trial[mrc_pkg::EXT_W-1:0];
			end
		end
	end

	// Pack: acc += coord * product of lower extents, then extend the product
	always_comb begin
		acc_n  = in_acc;
		mult_n = in_mult;
		if (SUB == 0 && active) begin
			acc_n  = in_acc + INDEX_BITS'(in_coord[DIM] * in_mult);
			mult_n = INDEX_BITS'(in_mult * ext);
		end
	end

	// Remainder of the last divide stage is this dimension's coordinate
	always_comb begin
		coord_n = in_coord;
		if (SUB == DIV_STAGES - 1 && active && in_kind) begin
			coord_n[DIM] = COORD_BITS'(rem_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1  <= in_kind;
		num_s1   <= num_n;
		rem_s1   <= rem_n;
		acc_s1   <= acc_n;
		mult_s1  <= mult_n;
		coord_s1 <= coord_n;
	end

	assign out_valid = valid_s1;
	assign out_kind  = kind_s1;
	assign out_num   = num_s1;
	assign out_rem   = rem_s1;
	assign out_acc   = acc_s1;
	assign out_mult  = mult_s1;
	assign out_coord = coord_s1;

endmodule

`default_nettype wire

FILE: rtl/mixed_radix_index_convert_core.sv
// Top level of the mixed-radix index converter: APB registers and the stage pipeline.
// Depends on mrc_pkg, mrc_regs and mrc_stage.
`default_nettype none

// Converts coordinates to a linear index (kind 0) or a linear index to coordinates
// (kind 1), dimension 0 fastest. busy is always low: a new item is taken on every
// cycle that start is high, and each item's result appears on the result ports with
// done high for one cycle. The pipeline length is set by the radix-16 restoring
// divider, four quotient bits per stage, run once per dimension; the receiver
// cannot stall it. Configuration must only be written while no item is in flight.
module mixed_radix_index_convert_core #(
	parameter int MAX_DIMS   = mrc_pkg::DEF_MAX_DIMS,
	parameter int COORD_BITS = mrc_pkg::DEF_COORD_BITS,
	parameter int INDEX_BITS = mrc_pkg::DEF_INDEX_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mrc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mrc_pkg::REG_W-1:0]   pwdata,
	output logic      [mrc_pkg::REG_W-1:0]   prdata,
	output logic                             pready,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        kind,
	input  wire logic [INDEX_BITS-1:0]       index_in,
	input  wire logic [COORD_BITS-1:0]       coord_in_0,
	input  wire logic [COORD_BITS-1:0]       coord_in_1,
	input  wire logic [COORD_BITS-1:0]       coord_in_2,
	input  wire logic [COORD_BITS-1:0]       coord_in_3,
	output logic                             done,
	output logic      [INDEX_BITS-1:0]       index_out,
	output logic      [COORD_BITS-1:0]       coord_out_0,
	output logic      [COORD_BITS-1:0]       coord_out_1,
	output logic      [COORD_BITS-1:0]       coord_out_2,
	output logic      [COORD_BITS-1:0]       coord_out_3
);

	localparam int CAP        = (MAX_DIMS < mrc_pkg::FIELD_DIMS) ? MAX_DIMS
	                            : mrc_pkg::FIELD_DIMS;
	localparam int DIV_STAGES = (INDEX_BITS + mrc_pkg::STEP_BITS - 1) / mrc_pkg::STEP_BITS;
	localparam int NUM_W      = DIV_STAGES * mrc_pkg::STEP_BITS;
	localparam int LAT        = CAP * DIV_STAGES;

	mrc_pkg::cfg_t cfg;

	logic                                              p_valid [LAT+1];
	logic                                              p_kind  [LAT+1];
	logic [NUM_W-1:0]                                  p_num   [LAT+1];
	logic [mrc_pkg::EXT_W-1:0]                         p_rem   [LAT+1];
	logic [INDEX_BITS-1:0]                             p_acc   [LAT+1];
	logic [INDEX_BITS-1:0]                             p_mult  [LAT+1];
	logic [mrc_pkg::FIELD_DIMS-1:0][COORD_BITS-1:0]    p_coord [LAT+1];
	logic [mrc_pkg::FIELD_DIMS-1:0][COORD_BITS-1:0]    res_coord;

	mrc_regs #(
		.MAX_DIMS(MAX_DIMS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// Pipeline entry: every start is a transfer
	assign busy       = 1'b0;
	assign p_valid[0] = start && !busy;
	assign p_kind[0]  = kind;
	assign p_num[0]   = NUM_W'(index_in);
	assign p_rem[0]   = '0;
	assign p_acc[0]   = '0;
	assign p_mult[0]  = INDEX_BITS'(1);
	assign p_coord[0] = {coord_in_3, coord_in_2, coord_in_1, coord_in_0};

	// Stage chain: DIV_STAGES stages per dimension
	for (genvar k = 0; k < LAT; k++) begin : g_stage
		mrc_stage #(
			.INDEX_BITS(INDEX_BITS),
			.COORD_BITS(COORD_BITS),
			.NUM_W(NUM_W),
			.DIV_STAGES(DIV_STAGES),
			.DIM(k / DIV_STAGES),
			.SUB(k % DIV_STAGES)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.cfg(cfg),
			.in_valid(p_valid[k]),
			.in_kind(p_kind[k]),
			.in_num(p_num[k]),
			.in_rem(p_rem[k]),
			.in_acc(p_acc[k]),
			.in_mult(p_mult[k]),
			.in_coord(p_coord[k]),
			.out_valid(p_valid[k+1]),
			.out_kind(p_kind[k+1]),
			.out_num(p_num[k+1]),
			.out_rem(p_rem[k+1]),
			.out_acc(p_acc[k+1]),
			.out_mult(p_mult[k+1]),
			.out_coord(p_coord[k+1])
		);
	end

	// Result: zero the fields the other direction does not produce
	always_comb begin
		for (int d = 0; d < mrc_pkg::FIELD_DIMS; d++) begin
			res_coord[d] = (p_kind[LAT] && (mrc_pkg::CNT_W'(d) < cfg.dims))
			               ? p_coord[LAT][d] : '0;
		end
	end

	assign done        = p_valid[LAT];
	assign index_out   = p_kind[LAT] ? '0 : p_acc[LAT];
	assign coord_out_0 = res_coord[0];
	assign coord_out_1 = res_coord[1];
	assign coord_out_2 = res_coord[2];
	assign coord_out_3 = res_coord[3];

`ifndef NO_ASSERTIONS
	// Every result traces back to a start at the pipeline input
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching start");

	// A packed index and unpacked coordinates never appear together
	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_out != '0) |-> (coord_out_0 == '0 && coord_out_1 == '0
			&& coord_out_2 == '0 && coord_out_3 == '0))
		else $error("index and coordinates both non-zero");
`endif

endmodule

`default_nettype wire
